/* design/amc_pkg.sv */
// Shared constants and types for the amicable number checker.
// No dependencies; amc_sequencer and amicable_number_checker refer to this package by scoped names.
package amc_pkg;

   // Default width of the number under test
   localparam int NUMBER_WIDTH_DEF = 16;

   // Divisor sum accumulator range
   localparam int SUM_WIDTH = 20;
   localparam logic [SUM_WIDTH-1:0] SUM_LIMIT = {SUM_WIDTH{1'b1}};

   // Response packing: has_partner, divisor_sum, overflow, padded to bytes
   localparam int RSP_FIELDS_W = SUM_WIDTH + 2;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_DATA_W - RSP_FIELDS_W;

   // Result of one request
   typedef struct packed {
      logic                 overflow;
      logic [SUM_WIDTH-1:0] divisor_sum;
      logic                 has_partner;
   } result_type;

   // Sequencer status toward the stream interface
   typedef struct packed {
      logic idle;
      logic done;
   } seq_status_type;

endpackage

/* design/amc_rem_unit.sv */
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
// Depends on nothing but its parameter; used by amc_sequencer.
module amc_rem_unit #(
   parameter int VAL_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] dividend,
   input  logic [VAL_W-1:0] divisor,
   output logic             done,
   output logic             is_zero
);

   localparam int CNT_W = $clog2(VAL_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] quo_ff, quo_in;
   logic [VAL_W-1:0] div_ff, div_in;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [VAL_W:0]   trial;
   logic [VAL_W:0]   trial_diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial      = {rem_ff, quo_ff[VAL_W-1]};
      trial_diff = trial - {1'b0, div_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VAL_W);
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VAL_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial_diff[VAL_W-1:0];
         end else begin
            rem_in = trial[VAL_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done    = done_ff;
   assign is_zero = (rem_ff == '0);

   // A new trial never starts on top of one in progress
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit started while busy");

endmodule

/* design/amc_sequencer.sv */
// Sequencer for both divisor-sum passes, driving the shared remainder unit.
// Depends on amc_pkg and amc_rem_unit.
module amc_sequencer #(
   parameter int NUMBER_WIDTH = amc_pkg::NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] start_number,
   input  logic                    out_free,
   output amc_pkg::seq_status_type status,
   output amc_pkg::result_type     result
);

   localparam int SUM_W = amc_pkg::SUM_WIDTH;
   localparam int VAL_W = (NUMBER_WIDTH > SUM_W) ? NUMBER_WIDTH : SUM_W;
   localparam int EXT_W = VAL_W + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_WAIT,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] number_ff, number_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [VAL_W-1:0] div_ff, div_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] first_ff, first_in;
   logic             pass_ff, pass_in;
   logic             ovf_ff, ovf_in;
   logic             partner_ff, partner_in;
   logic             rem_start;
   logic             rem_done;
   logic             rem_zero;
   logic [EXT_W-1:0] sum_next;

   amc_rem_unit #(
      .VAL_W(VAL_W)
   ) u_rem (
      .clock   (clock),
      .reset   (reset),
      .start   (rem_start),
      .dividend(value_ff),
      .divisor (div_ff),
      .done    (rem_done),
      .is_zero (rem_zero)
   );

   // Step through trial divisors, then the second pass, then hand off the result (early on overflow)
   always_comb begin
      state_in   = state_ff;
      number_in  = number_ff;
      value_in   = value_ff;
      div_in     = div_ff;
      acc_in     = acc_ff;
      first_in   = first_ff;
      pass_in    = pass_ff;
      ovf_in     = ovf_ff;
      partner_in = partner_ff;
      rem_start  = 1'b0;
      sum_next   = EXT_W'(acc_ff) + EXT_W'(div_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               number_in  = VAL_W'(start_number);
               value_in   = VAL_W'(start_number);
               div_in     = VAL_W'(1);
               acc_in     = '0;
               pass_in    = 1'b0;
               ovf_in     = 1'b0;
               partner_in = 1'b0;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (div_ff < value_ff) begin
               rem_start = 1'b1;
               state_in  = S_WAIT;
            end else if (!pass_ff) begin
               // First sum complete: now sum the divisors of that sum
               first_in = acc_ff;
               value_in = VAL_W'(acc_ff);
               div_in   = VAL_W'(1);
               acc_in   = '0;
               pass_in  = 1'b1;
            end else begin
               partner_in = (VAL_W'(acc_ff) == number_ff) &&
                            (VAL_W'(first_ff) != number_ff);
               state_in   = S_DONE;
            end
         end
         S_WAIT: begin
            if (rem_done) begin
               div_in   = div_ff + 1'b1;
               state_in = S_CHECK;
               if (rem_zero) begin
                  if (sum_next > EXT_W'(amc_pkg::SUM_LIMIT)) begin
                     // Accumulator range passed: stop, saturate a first sum
                     ovf_in     = 1'b1;
                     partner_in = 1'b0;
                     if (!pass_ff) begin
                        first_in = amc_pkg::SUM_LIMIT;
                     end
                     state_in = S_DONE;
                  end else begin
                     acc_in = sum_next[SUM_W-1:0];
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pass_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
         partner_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pass_ff    <= pass_in;
         ovf_ff     <= ovf_in;
         partner_ff <= partner_in;
      end
      number_ff <= number_in;
      value_ff  <= value_in;
      div_ff    <= div_in;
      acc_ff    <= acc_in;
      first_ff  <= first_in;
   end

   assign status.idle        = (state_ff == S_IDLE);
   assign status.done        = (state_ff == S_DONE) && out_free;
   assign result.has_partner = partner_ff;
   assign result.divisor_sum = first_ff;
   assign result.overflow    = ovf_ff;

   // Operands hold steady while the remainder unit works on them
   a_wait_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |=> (state_ff != S_WAIT) ||
                               ($stable(div_ff) && $stable(value_ff)))
      else $error("trial operands changed during remainder");

   // Only proper divisors are tried
   a_proper_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (div_ff < value_ff) && (div_ff != '0))
      else $error("trial divisor out of range");

   // An overflowed result never claims a partner
   a_ovf_no_partner: assert property (@(posedge clock) disable iff (reset)
      status.done |-> !(ovf_ff && partner_ff))
      else $error("partner flagged on overflow");

endmodule

/* design/amicable_number_checker.sv */
// Amicable number checker: a request of value n returns its divisor sum and partner flag.
// Each trial divisor from 1 below n, then below the first sum s, goes to the bit-serial remainder
// unit (one quotient bit per cycle), W = max(NUMBER_WIDTH, 20) bits wide. One request at a time:
// a new request is accepted only once the sequencer is idle again. The response register frees
// the sequencer once the result is taken or buffered.
// Reset is synchronous, active high, and clears the sequencer and the response valid.
module amicable_number_checker #(
   parameter int NUMBER_WIDTH = amc_pkg::NUMBER_WIDTH_DEF,
   localparam int REQ_DATA_W = ((NUMBER_WIDTH + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_DATA_W-1:0]         req_tdata,  // number
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [amc_pkg::RSP_DATA_W-1:0] rsp_tdata   // has_partner, divisor_sum, overflow
);

   amc_pkg::seq_status_type        status;
   amc_pkg::result_type            result;
   logic                           req_accept;
   logic                           out_free;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [amc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = status.idle;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   amc_sequencer #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .start_number(req_tdata[NUMBER_WIDTH-1:0]),
      .out_free    (out_free),
      .status      (status),
      .result      (result)
   );

   // Load the response register on completion, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{amc_pkg::RSP_PAD_W{1'b0}}, result.overflow,
                         result.divisor_sum, result.has_partner};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted request keeps the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("ready stayed high after a request");

endmodule
